// ----- hw/rtl/alir_pkg.sv -----
// alir_pkg: shared widths, sizes and the control struct of the list cells
// used by the entry cells, the top level and the port checker; no dependencies
package alir_pkg;

  localparam int DEPTH   = 16;  // built number of entry cells
  localparam int VAL_W   = 32;  // stored word width
  localparam int CNT_W   = 5;   // count, position and capacity width
  localparam int S_DATA_W = 40; // position + operand, padded to bytes
  localparam int M_DATA_W = 8;  // count, padded to bytes

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // broadcast from the top level to every cell for one transfer
  typedef struct packed {
    logic             ins;    // accepted insert that succeeds
    logic             rem;    // accepted remove that found a match
    logic [CNT_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/alir_cell.sv -----
// alir_cell: one list entry; compares against the request value and
// moves its word up or down the row; depends on alir_pkg
module alir_cell (
  input  logic                                  clk,
  input  logic [alir_pkg::CNT_W-1:0]            idx,
  input  alir_pkg::cell_ctrl_t                  ctl,
  input  logic                                  shift_dn,
  input  logic [alir_pkg::VAL_W-1:0]            lower,
  input  logic [alir_pkg::VAL_W-1:0]            upper,
  output logic [alir_pkg::VAL_W-1:0]            entry,
  output logic                                  eq
);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        entry <= ctl.value;
      end else if (idx > ctl.pos) begin
        entry <= lower;
      end
    end else if (ctl.rem && shift_dn) begin
      entry <= upper;
    end
  end

  assign eq = (entry == ctl.value);

endmodule

// ----- hw/rtl/array_list_insert_remove.sv -----
// array_list_insert_remove: top level, a row of alir_cell entries with count,
// capacity register and result register; depends on alir_pkg and alir_cell
//
// Ordered list of up to 16 signed 32-bit words. A request (tuser = opcode:
// 0 insert at position, 1 remove first match) is taken on a slave transfer;
// its result (success flag and new count) appears in the next cycle in the
// output register and waits there until taken. One request per cycle is
// sustained: every cell compares and shifts in the same cycle, so the rate
// is set by the combinational compare, first-match pick and shift across the
// cell row. The input stalls only while a result is held back by the master
// side. Inserts are rejected when the count has reached min(capacity, 16)
// or the position lies past the count; a remove with no match changes
// nothing. The capacity register is written through the cfg channel, which
// is always ready, and resets to 16. Entries hold no reset value; only
// entries below the count can produce a match.
module array_list_insert_remove (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alir_pkg::CNT_W-1:0]       cfg_data,    // capacity_limit
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [alir_pkg::S_DATA_W-1:0]    s_tdata,     // position[4:0], operand_value[36:5], zeros
  input  logic                             s_tuser,     // opcode
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [alir_pkg::M_DATA_W-1:0]    m_tdata,     // count_after[4:0], zeros
  output logic                             m_tuser      // success
);

  localparam int D = alir_pkg::DEPTH;
  localparam int C = alir_pkg::CNT_W;
  localparam int V = alir_pkg::VAL_W;

  logic [C-1:0]        capacity;
  logic [C-1:0]        count;
  logic [C-1:0]        count_next;
  logic [C-1:0]        cap_eff;
  logic                s_xfer;
  logic [C-1:0]        req_pos;
  logic [V-1:0]        req_val;
  logic                ins_ok;
  logic                rem_ok;
  alir_pkg::cell_ctrl_t ctl;

  logic [V-1:0]        entry [D];
  logic [D-1:0]        eq;
  logic [D-1:0]        occ;
  logic [D-1:0]        hit;
  logic [D-1:0]        first;
  logic [D-1:0]        shift_dn;

  // capacity register; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= alir_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  assign cap_eff = (capacity > alir_pkg::DEPTH_CNT) ? alir_pkg::DEPTH_CNT : capacity;

  // request decode
  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;
  assign req_pos  = s_tdata[C-1:0];
  assign req_val  = s_tdata[C+V-1:C];

  // occupied cells and first match, lowest index wins
  always_comb begin
    for (int i = 0; i < D; i++) begin
      occ[i] = (C'(i) < count);
    end
  end

  assign hit      = eq & occ;
  assign first    = hit & (~hit + D'(1));
  // cells at and above the first match take their upper neighbour
  assign shift_dn = ~(first - D'(1));

  assign ins_ok = (s_tuser == alir_pkg::OP_INSERT) && (count < cap_eff) && (req_pos <= count);
  assign rem_ok = (s_tuser == alir_pkg::OP_REMOVE) && (|hit);

  assign ctl.ins   = s_xfer && ins_ok;
  assign ctl.rem   = s_xfer && rem_ok;
  assign ctl.pos   = req_pos;
  assign ctl.value = req_val;

  // row of entry cells, each linked to both neighbours
  for (genvar g = 0; g < D; g++) begin : g_cell
    logic [V-1:0] lower_w;
    logic [V-1:0] upper_w;

    if (g == 0) begin : g_lo
      assign lower_w = '0;
    end else begin : g_lo
      assign lower_w = entry[g-1];
    end

    if (g == D - 1) begin : g_hi
      assign upper_w = '0;
    end else begin : g_hi
      assign upper_w = entry[g+1];
    end

    alir_cell u_cell (
      .clk      (clk),
      .idx      (C'(g)),
      .ctl      (ctl),
      .shift_dn (shift_dn[g]),
      .lower    (lower_w),
      .upper    (upper_w),
      .entry    (entry[g]),
      .eq       (eq[g])
    );
  end

  // element count
  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + C'(1);
    end else if (ctl.rem) begin
      count_next = count - C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register, loaded on every request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      m_tuser <= ins_ok || rem_ok;
      m_tdata <= alir_pkg::M_DATA_W'(count_next);
    end
  end

endmodule

// ----- hw/rtl/alir_checker.sv -----
// alir_checker: port-level checks on the list block, bound to the top level
// depends on alir_pkg and array_list_insert_remove
module alir_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [alir_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                             m_tuser
);

  // every request transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after request transfer");

  // the input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("request side stalled without a held result");

  // reported count never exceeds the built depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[alir_pkg::CNT_W-1:0] <= alir_pkg::DEPTH_CNT)
    else $error("count above depth");

  // a held result stays unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held result changed");

endmodule

bind array_list_insert_remove alir_checker u_alir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- dv/tb.sv -----
// tb: self-checking bench for array_list_insert_remove, mixed insert and remove traffic
// under several capacity settings with random gaps on both streams
// depends on alir_pkg and the array_list_insert_remove rtl

// shadow list that predicts every result and compares the results in order
class list_scoreboard;

  typedef struct {
    logic             ok;
    logic [alir_pkg::CNT_W-1:0] cnt;
  } list_result_t;

  logic [alir_pkg::VAL_W-1:0] words [alir_pkg::DEPTH];
  logic [alir_pkg::CNT_W-1:0] fill;
  logic [alir_pkg::CNT_W-1:0] cap_reg;
  list_result_t               expected_results [$];

  int errors;
  int n_checked;
  int n_ins_ok, n_ins_rej, n_rem_hit, n_rem_miss;
  int peak_fill;

  function new();
    fill      = '0;
    cap_reg   = alir_pkg::CAP_RESET;
    errors    = 0;
    n_checked = 0;
    n_ins_ok  = 0;
    n_ins_rej = 0;
    n_rem_hit = 0;
    n_rem_miss = 0;
    peak_fill = 0;
  endfunction

  function void set_capacity(logic [alir_pkg::CNT_W-1:0] v);
    cap_reg = v;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void fail_note(string msg);
    errors++;
    if (errors <= 10) $display("tb: mismatch: %s", msg);
  endfunction

  // apply one accepted request to the shadow list
  function void note_request(logic op, logic [alir_pkg::CNT_W-1:0] pos,
                             logic [alir_pkg::VAL_W-1:0] val);
    list_result_t r;
    int lim;
    int hit;
    int i;
    int k;
    lim  = (cap_reg > alir_pkg::DEPTH) ? alir_pkg::DEPTH : int'(cap_reg);
    r.ok = 1'b0;
    if (op == alir_pkg::OP_INSERT) begin
      if (int'(fill) < lim && pos <= fill) begin
        for (k = int'(fill); k > int'(pos); k--) words[k] = words[k-1];
        words[pos] = val;
        fill++;
        r.ok = 1'b1;
        n_ins_ok++;
      end else begin
        n_ins_rej++;
      end
    end else begin
      hit = -1;
      for (i = 0; i < int'(fill); i++)
        if (hit < 0 && words[i] == val) hit = i;
      if (hit >= 0) begin
        for (k = hit; k + 1 < int'(fill); k++) words[k] = words[k+1];
        fill--;
        r.ok = 1'b1;
        n_rem_hit++;
      end else begin
        n_rem_miss++;
      end
    end
    if (int'(fill) > peak_fill) peak_fill = int'(fill);
    r.cnt = fill;
    expected_results.push_back(r);
  endfunction

  // compare one result transfer with the oldest prediction
  function void check_result(logic ok, logic [alir_pkg::CNT_W-1:0] cnt);
    list_result_t e;
    n_checked++;
    if (expected_results.size() == 0) begin
      fail_note($sformatf("unexpected result ok=%0b count=%0d", ok, cnt));
      return;
    end
    e = expected_results.pop_front();
    if (ok !== e.ok || cnt !== e.cnt)
      fail_note($sformatf("result %0d: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                          n_checked, e.ok, e.cnt, ok, cnt));
  endfunction

endclass

module tb;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [alir_pkg::CNT_W-1:0]    cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [alir_pkg::S_DATA_W-1:0] s_tdata;   // position[4:0], operand_value[36:5], zeros
  logic                          s_tuser;   // opcode
  logic                          m_tvalid;
  logic                          m_tready;
  logic [alir_pkg::M_DATA_W-1:0] m_tdata;   // count_after[4:0], zeros
  logic                          m_tuser;   // success

  list_scoreboard sb;

  // no idling on either stream while set
  logic quiet;
  int   stall_left;
  int   n_cfg_writes;

  array_list_insert_remove dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 8 unit clock period
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // idle length: mostly short, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // gap before a request: none most of the time
  function automatic int request_gap();
    if (quiet || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= idle_len() - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // every result transfer is checked against the shadow list
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[alir_pkg::CNT_W-1:0]);
  end

  // drive one request and hold it until its transfer, then update the shadow list
  task automatic send_request(input logic op, input logic [alir_pkg::CNT_W-1:0] pos,
                              input logic [alir_pkg::VAL_W-1:0] val, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(alir_pkg::S_DATA_W-alir_pkg::VAL_W-alir_pkg::CNT_W){1'b0}}, val, pos};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, pos, val);
  endtask

  // value pool: random words, a few small ones for duplicates, and the extremes
  function automatic logic [alir_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom();
    if (r < 80) return alir_pkg::VAL_W'($signed($urandom_range(0, 4)) - 2);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // random request shaped by the shadow list, so removes usually hit
  task automatic send_random(input int ins_pct);
    logic                       op;
    logic [alir_pkg::CNT_W-1:0] pos;
    logic [alir_pkg::VAL_W-1:0] val;
    int                         fill;
    int                         r;
    fill = int'(sb.fill);
    r    = $urandom_range(0, 99);
    pos  = alir_pkg::CNT_W'($urandom_range(0, alir_pkg::DEPTH));
    if ($urandom_range(0, 99) < ins_pct) begin
      op = alir_pkg::OP_INSERT;
      if (r < 80)      pos = alir_pkg::CNT_W'($urandom_range(0, fill));
      else if (r < 90) pos = alir_pkg::CNT_W'((fill < alir_pkg::DEPTH) ? fill + 1
                                                                       : alir_pkg::DEPTH);
      val = pick_value();
    end else begin
      op = alir_pkg::OP_REMOVE;
      if (fill > 0 && r < 70) val = sb.words[$urandom_range(0, fill - 1)];
      else                    val = pick_value();
    end
    send_request(op, pos, val, request_gap());
  endtask

  // capacity write, only once every outstanding result has come back
  task automatic write_capacity(input logic [alir_pkg::CNT_W-1:0] v);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(v);
    n_cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [alir_pkg::CNT_W-1:0] cap, input int ins_pct,
                              input logic no_idle, input int n);
    write_capacity(cap);
    quiet <= no_idle;
    repeat (n) send_random(ins_pct);
  endtask

  initial begin
    int wait_cycles;
    sb           = new();
    n_cfg_writes = 0;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = alir_pkg::OP_INSERT;
    quiet        = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, past-end insert, append, extremes, duplicates
    send_request(alir_pkg::OP_REMOVE, 5'd16, 32'h0000_0000, 0);  // remove from empty
    send_request(alir_pkg::OP_INSERT, 5'd1,  32'h0000_0005, 0);  // position past end
    send_request(alir_pkg::OP_INSERT, 5'd0,  32'h8000_0000, 0);
    send_request(alir_pkg::OP_INSERT, 5'd1,  32'h7fff_ffff, 1);  // append at count
    send_request(alir_pkg::OP_INSERT, 5'd0,  32'hffff_ffff, 0);
    send_request(alir_pkg::OP_INSERT, 5'd3,  32'h0000_0000, 0);
    send_request(alir_pkg::OP_INSERT, 5'd5,  32'h0000_0001, 0);  // position past end
    send_request(alir_pkg::OP_INSERT, 5'd2,  32'h7fff_ffff, 3);  // duplicate ahead of the first
    send_request(alir_pkg::OP_REMOVE, 5'd0,  32'h7fff_ffff, 0);  // lowest match only
    send_request(alir_pkg::OP_REMOVE, 5'd7,  32'h0000_3039, 0);  // no match
    send_request(alir_pkg::OP_REMOVE, 5'd0,  32'hffff_ffff, 0);  // head
    send_request(alir_pkg::OP_REMOVE, 5'd0,  32'h0000_0000, 0);  // tail

    // directed: list full at a small capacity, then capacity zero
    write_capacity(5'd3);
    send_request(alir_pkg::OP_INSERT, 5'd0,  32'haaaa_aaaa, 0);
    send_request(alir_pkg::OP_INSERT, 5'd0,  32'h5555_5555, 0);  // full
    send_request(alir_pkg::OP_INSERT, 5'd16, 32'h5555_5555, 0);  // full and past end
    write_capacity(5'd0);
    send_request(alir_pkg::OP_INSERT, 5'd0,  32'h1234_5678, 0);  // capacity zero
    send_request(alir_pkg::OP_REMOVE, 5'd0,  32'h7fff_ffff, 0);
    send_request(alir_pkg::OP_INSERT, 5'd2,  32'h1234_5678, 0);

    // random phases over a spread of capacities, two with no idling
    random_phase(5'd16, 60, 1'b0, 100);
    random_phase(5'd31, 80, 1'b0, 100);   // above depth, fills the list
    random_phase(5'd1,  60, 1'b0, 80);
    random_phase(5'd17, 55, 1'b1, 100);
    random_phase(5'd0,  50, 1'b0, 60);
    random_phase(5'd5,  55, 1'b0, 100);
    random_phase(alir_pkg::CNT_W'($urandom_range(2, 15)), 55, 1'b0, 100);
    random_phase(5'd16, 70, 1'b1, 80);
    random_phase(5'd16, 45, 1'b0, 80);

    // drain: every prediction must be matched, then a short tail for strays
    s_tvalid <= 1'b0;
    quiet    <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.fail_note($sformatf("%0d results never arrived", sb.pending()));

    $display("tb: %0d results checked, %0d capacity writes, peak count %0d",
             sb.n_checked, n_cfg_writes, sb.peak_fill);
    $display("tb: inserts %0d done %0d rejected, removes %0d hit %0d missed, %0d mismatches",
             sb.n_ins_ok, sb.n_ins_rej, sb.n_rem_hit, sb.n_rem_miss, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
